/* rtl/bellman_ford_negative_cycle_macros.svh */
// Assertion macros for the negative-cycle detector checker.
`ifndef BELLMAN_FORD_NEGATIVE_CYCLE_MACROS_SVH
`define BELLMAN_FORD_NEGATIVE_CYCLE_MACROS_SVH

// same-cycle implication, disabled in reset
`define BFNC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BFNC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define BFNC_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bfnc_pkg.sv */
// Types and constants shared by the negative-cycle detector.
package bfnc_pkg;

  localparam int NODE_W = 6;
  localparam int WGT_W  = 16;
  localparam int DIST_W = 64;
  localparam int EDGE_W = 2 * NODE_W + WGT_W;
  localparam int CNT_W  = NODE_W + 1;

  localparam logic signed [DIST_W-1:0] SENTINEL = 64'sd1000000000000000000;

  localparam logic CFG_NODE_COUNT  = 1'b0;
  localparam logic CFG_SOURCE_NODE = 1'b1;

  typedef enum logic [11:0] {
    ST_LOAD     = 12'b0000_0000_0001,
    ST_START    = 12'b0000_0000_0010,
    ST_SCAN_RD  = 12'b0000_0000_0100,
    ST_SCAN_EDG = 12'b0000_0000_1000,
    ST_SCAN_REL = 12'b0000_0001_0000,
    ST_NO       = 12'b0000_0010_0000,
    ST_WALK     = 12'b0000_0100_0000,
    ST_WALK_GET = 12'b0000_1000_0000,
    ST_COL_RD   = 12'b0001_0000_0000,
    ST_COL_GET  = 12'b0010_0000_0000,
    ST_EMIT_RD  = 12'b0100_0000_0000,
    ST_EMIT_OUT = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic                     clr;
    logic [NODE_W-1:0]        zero_node;
    logic [NODE_W-1:0]        rd_a;
    logic [NODE_W-1:0]        rd_b;
    logic                     we;
    logic [NODE_W-1:0]        wr_addr;
    logic signed [DIST_W-1:0] wr_dist;
    logic [NODE_W-1:0]        wr_par;
  } node_req_t;

  typedef struct packed {
    logic signed [DIST_W-1:0] dist_a;
    logic signed [DIST_W-1:0] dist_b;
    logic [NODE_W-1:0]        par_a;
  } node_rsp_t;

endpackage

/* rtl/bfnc_in_if.sv */
// Edge input channel.
interface bfnc_in_if;
  logic                                valid;
  logic                                ready;
  logic [bfnc_pkg::NODE_W-1:0]         from_node;
  logic [bfnc_pkg::NODE_W-1:0]         to_node;
  logic signed [bfnc_pkg::WGT_W-1:0]   weight;
  logic                                last_edge;

  modport source (output valid, from_node, to_node, weight, last_edge, input ready);
  modport sink (input valid, from_node, to_node, weight, last_edge, output ready);
endinterface

/* rtl/bfnc_out_if.sv */
// Result output channel.
interface bfnc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        has_cycle;
  logic [bfnc_pkg::NODE_W-1:0] cycle_node;
  logic                        last_result;

  modport source (output valid, has_cycle, cycle_node, last_result, input ready);
  modport sink (input valid, has_cycle, cycle_node, last_result, output ready);
endinterface

/* rtl/bfnc_edge_mem.sv */
// Edge store: one write port, one registered read port.
module bfnc_edge_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [bfnc_pkg::EDGE_W-1:0]   wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [bfnc_pkg::EDGE_W-1:0]   rdata
);

  logic [bfnc_pkg::EDGE_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/bfnc_node_mem.sv */
// Distance and parent store with per-node valid bits and two read ports.
module bfnc_node_mem #(
  parameter int MAX_NODES = 63
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bfnc_pkg::node_req_t   req,
  output bfnc_pkg::node_rsp_t   rsp
);

  logic signed [bfnc_pkg::DIST_W-1:0] dist_mem [0:MAX_NODES];
  logic [bfnc_pkg::NODE_W-1:0]        par  [0:MAX_NODES];
  logic [MAX_NODES:0]                 valid;

  logic signed [bfnc_pkg::DIST_W-1:0] da;
  logic signed [bfnc_pkg::DIST_W-1:0] db;
  logic [bfnc_pkg::NODE_W-1:0]        pa;
  logic                               va;
  logic                               vb;
  logic                               za;
  logic                               zb;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.clr) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      dist_mem[req.wr_addr] <= req.wr_dist;
      par[req.wr_addr]      <= req.wr_par;
    end
    da <= dist_mem[req.rd_a];
    db <= dist_mem[req.rd_b];
    pa <= par[req.rd_a];
    va <= valid[req.rd_a];
    vb <= valid[req.rd_b];
    za <= (req.zero_node != '0) && (req.rd_a == req.zero_node);
    zb <= (req.zero_node != '0) && (req.rd_b == req.zero_node);
  end

  always_comb begin
    rsp.dist_a = va ? da : (za ? '0 : bfnc_pkg::SENTINEL);
    rsp.dist_b = vb ? db : (zb ? '0 : bfnc_pkg::SENTINEL);
    rsp.par_a  = va ? pa : '0;
  end

endmodule

/* rtl/bellman_ford_negative_cycle.sv */
// Negative-cycle detector: edges load one per cycle (in_ch.ready is high while loading).
// The edge marked last_edge starts the solve, during which no edge is accepted. The solve
// runs n rounds; each round visits nodes 1..n and, for each node, reads every stored edge
// from the edge memory, so it takes n*n*E edge visits. A visit passes through ST_SCAN_RD
// and ST_SCAN_EDG; when the edge's tail is the current node and its head lies in 1..n, it
// also passes through ST_SCAN_REL (edge read, then distance read and write-back through
// the node memory). Afterwards the cycle walk takes each parent step through a read state
// and a get state (n-1 steps plus up to n collection steps), and each result is then
// read from the cycle buffer through ST_EMIT_RD and ST_EMIT_OUT, or one result follows at
// once when no cycle is found. Distances reset at solve start through valid bits.
module bellman_ford_negative_cycle #(
  parameter int MAX_NODES = 63,
  parameter int MAX_EDGES = 256
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bfnc_pkg::NODE_W-1:0] cfg_data,
  bfnc_in_if.sink                     in_ch,
  bfnc_out_if.source                  out_ch
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int NW  = bfnc_pkg::NODE_W;
  localparam int CW  = bfnc_pkg::CNT_W;

  bfnc_pkg::state_t state;

  logic [NW-1:0]  node_count;
  logic [NW-1:0]  source_node;
  logic [ECW-1:0] edge_total;
  logic [NW-1:0]  n;
  logic [NW-1:0]  zero_node;
  logic [NW-1:0]  rnd;
  logic [NW-1:0]  node;
  logic [EAW-1:0] k;
  logic           found;
  logic [NW-1:0]  last_imp;
  logic [NW-1:0]  sel;
  logic [NW-1:0]  first;
  logic [NW-1:0]  step;
  logic [CW-1:0]  cnt;
  logic [CW-1:0]  idx;
  logic [NW-1:0]  e_u;
  logic [NW-1:0]  e_v;
  logic signed [bfnc_pkg::WGT_W-1:0] e_w;

  logic           ov;
  logic           o_has;
  logic [NW-1:0]  o_node;
  logic           o_last;

  logic [NW-1:0]  cbuf [0:(1 << NW) - 1];
  logic [NW-1:0]  cb_q;

  logic [bfnc_pkg::EDGE_W-1:0] e_rd;
  logic           in_xfer;
  logic           edge_we;
  logic [NW-1:0]  n_eff;
  logic [NW-1:0]  rd_u;
  logic [NW-1:0]  rd_v;
  logic           hit;
  logic signed [bfnc_pkg::DIST_W-1:0] cand;
  logic           relax;
  logic           k_last;
  logic           node_last;
  logic           rnd_last;
  logic           found_now;
  logic           out_free;
  logic           o_load;
  logic [CW-1:0]  cnt_new;

  bfnc_pkg::node_req_t req;
  bfnc_pkg::node_rsp_t rsp;

  assign in_ch.ready  = (state == bfnc_pkg::ST_LOAD);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign edge_we      = in_xfer && (edge_total < ECW'(MAX_EDGES));
  assign n_eff        = (node_count > NW'(MAX_NODES)) ? NW'(MAX_NODES) : node_count;
  assign out_free     = !ov || out_ch.ready;
  assign o_load       = out_free &&
                        ((state == bfnc_pkg::ST_NO) || (state == bfnc_pkg::ST_EMIT_OUT));

  assign out_ch.valid       = ov;
  assign out_ch.has_cycle   = o_has;
  assign out_ch.cycle_node  = o_node;
  assign out_ch.last_result = o_last;

  assign rd_u      = e_rd[NW-1:0];
  assign rd_v      = e_rd[2*NW-1:NW];
  assign hit       = (rd_u == node) && (rd_v != '0) && (rd_v <= n);
  assign cand      = rsp.dist_a + bfnc_pkg::DIST_W'(e_w);
  assign relax     = cand < rsp.dist_b;
  assign k_last    = (ECW'(k) + ECW'(1)) >= edge_total;
  assign node_last = (node == n);
  assign rnd_last  = (rnd == n);
  assign found_now = found || ((state == bfnc_pkg::ST_SCAN_REL) && relax && rnd_last);
  assign cnt_new   = cnt + CW'(1);

  bfnc_edge_mem #(
    .DEPTH (MAX_EDGES),
    .AW    (EAW)
  ) u_edge_mem (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_total[EAW-1:0]),
    .wdata ({in_ch.weight, in_ch.to_node, in_ch.from_node}),
    .raddr (k),
    .rdata (e_rd)
  );

  always_comb begin
    req           = '0;
    req.zero_node = zero_node;
    req.clr       = (state == bfnc_pkg::ST_START);
    req.wr_addr   = e_v;
    req.wr_dist   = cand;
    req.wr_par    = e_u;
    req.rd_a      = sel;
    case (state)
      bfnc_pkg::ST_SCAN_EDG: begin
        req.rd_a = rd_u;
        req.rd_b = rd_v;
      end
      bfnc_pkg::ST_SCAN_REL: begin
        req.we = relax;
      end
      default: begin
      end
    endcase
  end

  bfnc_node_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_node_mem (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (state == bfnc_pkg::ST_WALK && step == n - NW'(1)) begin
      cbuf[0] <= sel;
    end else if (state == bfnc_pkg::ST_COL_GET) begin
      cbuf[cnt[NW-1:0]] <= rsp.par_a;
    end
    cb_q <= cbuf[NW'(cnt - CW'(1) - idx)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NW'(1);
      source_node <= NW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bfnc_pkg::CFG_NODE_COUNT:  node_count  <= cfg_data;
        bfnc_pkg::CFG_SOURCE_NODE: source_node <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bfnc_pkg::ST_LOAD;
      edge_total <= '0;
      found      <= 1'b0;
      last_imp   <= '0;
      zero_node  <= '0;
      ov         <= 1'b0;
    end else begin
      if (o_load) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        bfnc_pkg::ST_LOAD: begin
          if (in_xfer) begin
            if (edge_we) begin
              edge_total <= edge_total + ECW'(1);
            end
            if (in_ch.last_edge) begin
              state <= bfnc_pkg::ST_START;
            end
          end
        end
        bfnc_pkg::ST_START: begin
          n         <= n_eff;
          zero_node <= (source_node != '0 && source_node <= n_eff) ? source_node : '0;
          found     <= 1'b0;
          last_imp  <= '0;
          rnd       <= NW'(1);
          node      <= NW'(1);
          k         <= '0;
          if (n_eff == '0 || edge_total == '0) begin
            state <= bfnc_pkg::ST_NO;
          end else begin
            state <= bfnc_pkg::ST_SCAN_RD;
          end
        end
        bfnc_pkg::ST_SCAN_RD: begin
          state <= bfnc_pkg::ST_SCAN_EDG;
        end
        bfnc_pkg::ST_SCAN_EDG, bfnc_pkg::ST_SCAN_REL: begin
          if (state == bfnc_pkg::ST_SCAN_EDG && hit) begin
            e_u   <= rd_u;
            e_v   <= rd_v;
            e_w   <= e_rd[bfnc_pkg::EDGE_W-1:2*NW];
            state <= bfnc_pkg::ST_SCAN_REL;
          end else begin
            if (state == bfnc_pkg::ST_SCAN_REL && relax && rnd_last) begin
              found    <= 1'b1;
              last_imp <= e_v;
            end
            state <= bfnc_pkg::ST_SCAN_RD;
            if (!k_last) begin
              k <= k + EAW'(1);
            end else begin
              k <= '0;
              if (!node_last) begin
                node <= node + NW'(1);
              end else begin
                node <= NW'(1);
                if (!rnd_last) begin
                  rnd <= rnd + NW'(1);
                end else if (found_now) begin
                  sel        <= (state == bfnc_pkg::ST_SCAN_REL && relax) ? e_v : last_imp;
                  step       <= '0;
                  edge_total <= '0;
                  state      <= bfnc_pkg::ST_WALK;
                end else begin
                  state <= bfnc_pkg::ST_NO;
                end
              end
            end
          end
        end
        bfnc_pkg::ST_NO: begin
          edge_total <= '0;
          if (out_free) begin
            o_has  <= 1'b0;
            o_node <= '0;
            o_last <= 1'b1;
            state  <= bfnc_pkg::ST_LOAD;
          end
        end
        bfnc_pkg::ST_WALK: begin
          if (step == n - NW'(1)) begin
            first <= sel;
            cnt   <= CW'(1);
            state <= bfnc_pkg::ST_COL_RD;
          end else begin
            state <= bfnc_pkg::ST_WALK_GET;
          end
        end
        bfnc_pkg::ST_WALK_GET: begin
          sel   <= rsp.par_a;
          step  <= step + NW'(1);
          state <= bfnc_pkg::ST_WALK;
        end
        bfnc_pkg::ST_COL_RD: begin
          state <= bfnc_pkg::ST_COL_GET;
        end
        bfnc_pkg::ST_COL_GET: begin
          sel <= rsp.par_a;
          cnt <= cnt_new;
          if (rsp.par_a == first || cnt_new >= ({1'b0, n} + CW'(1))) begin
            idx   <= '0;
            state <= bfnc_pkg::ST_EMIT_RD;
          end else begin
            state <= bfnc_pkg::ST_COL_RD;
          end
        end
        bfnc_pkg::ST_EMIT_RD: begin
          state <= bfnc_pkg::ST_EMIT_OUT;
        end
        bfnc_pkg::ST_EMIT_OUT: begin
          if (out_free) begin
            o_has  <= 1'b1;
            o_node <= cb_q;
            o_last <= (idx + CW'(1) == cnt);
            idx    <= idx + CW'(1);
            if (idx + CW'(1) == cnt) begin
              state <= bfnc_pkg::ST_LOAD;
            end else begin
              state <= bfnc_pkg::ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= bfnc_pkg::ST_LOAD;
        end
      endcase
    end
  end

endmodule

/* rtl/bfnc_checker.sv */
// Port-level checks for the negative-cycle detector, bound to the top level.
`include "bellman_ford_negative_cycle_macros.svh"

module bfnc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last_edge,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        has_cycle,
  input logic [bfnc_pkg::NODE_W-1:0] cycle_node,
  input logic                        last_result
);

  `BFNC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cycle_node) && $stable(last_result), "result dropped or changed while stalled")
  `BFNC_ASSERT_NOW(a_no_cycle_single, out_valid && !has_cycle, last_result && cycle_node == '0, "no-cycle answer is not a single final result")
  `BFNC_ASSERT_NEXT(a_solve_blocks_input, in_valid && in_ready && in_last_edge, !in_ready, "edge accepted during solve")
  `BFNC_ASSERT_ALWAYS(a_reset_clears_out, rst, !out_valid, "result valid after reset")

endmodule

bind bellman_ford_negative_cycle bfnc_checker u_bfnc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last_edge (in_ch.last_edge),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .has_cycle    (out_ch.has_cycle),
  .cycle_node   (out_ch.cycle_node),
  .last_result  (out_ch.last_result)
);
